### sv/plld_pkg.sv
// shared types, widths, register indexes and saturation helpers for the
// pinhole projection with lens distortion block; no dependencies
package plld_pkg;

   localparam int DIV1_NUM_W = 48;
   localparam int DIV1_DEN_W = 32;
   localparam int DIV2_NUM_W = 37;
   localparam int DIV2_DEN_W = 16;

   localparam int CSR_COUNT = 8;
   localparam int CSR_IDX_W = 3;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_LO      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW0_HI      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_LO      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW1_HI      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_LO      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW2_HI      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_FOCUS = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_DISTORTION   = 3'd7;

   localparam logic [63:0] CENTER_FOCUS_RESET = 64'h0010_0010_0000_0000;

   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic              bad;
      logic signed [31:0] val;
   } sat_type;

   typedef struct packed {
      logic [15:0]        cx;
      logic [15:0]        cy;
      logic [15:0]        fx;
      logic [15:0]        fy;
      logic signed [15:0] k1;
      logic signed [15:0] k2;
      logic signed [15:0] p1;
      logic signed [15:0] p2;
   } lens_cfg_type;

   typedef struct packed {
      logic signed [31:0] z;
      logic               bad;
      logic               x_neg;
      logic               x_nz;
      logic               y_neg;
      logic               y_nz;
      logic               z_neg;
   } div1_side_type;

   typedef struct packed {
      logic signed [31:0] z;
      logic               bad;
      logic               x_neg;
      logic               x_nz;
      logic               y_neg;
      logic               y_nz;
   } div2_side_type;

   function automatic sat_type sat32(input logic signed [63:0] v);
      sat_type s;
      if (v > 64'sd2147483647) begin
         s.bad = 1'b1;
         s.val = Q_MAX;
      end else if (v < -64'sd2147483648) begin
         s.bad = 1'b1;
         s.val = Q_MIN;
      end else begin
         s.bad = 1'b0;
         s.val = v[31:0];
      end
      return s;
   endfunction

   // divide by zero follows the sign of the numerator
   function automatic sat_type zero_div(input logic neg, input logic nz);
      sat_type s;
      s.bad = 1'b1;
      if (!nz) begin
         s.val = '0;
      end else if (neg) begin
         s.val = Q_MIN;
      end else begin
         s.val = Q_MAX;
      end
      return s;
   endfunction

endpackage

### sv/plld_div.sv
// pipelined two-lane restoring divider, one quotient bit per stage
// depends on plld_pkg for default widths
module plld_div #(
   parameter int NUM_W  = plld_pkg::DIV1_NUM_W,
   parameter int DEN_W  = plld_pkg::DIV1_DEN_W,
   parameter int SIDE_W = 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  logic [1:0][NUM_W-1:0]     in_num,
   input  logic [1:0][DEN_W-1:0]     in_den,
   input  logic [SIDE_W-1:0]         in_side,
   output logic                      out_valid,
   output logic [1:0][NUM_W-1:0]     out_quot,
   output logic [SIDE_W-1:0]         out_side
);
   import plld_pkg::*;

   logic [NUM_W-1:0]            vld_ff;
   logic [NUM_W-1:0]            vld_in;
   logic [1:0][NUM_W-1:0]       numq_ff [NUM_W];
   logic [1:0][NUM_W-1:0]       numq_in [NUM_W];
   logic [1:0][DEN_W-1:0]       rem_ff  [NUM_W];
   logic [1:0][DEN_W-1:0]       rem_in  [NUM_W];
   logic [1:0][DEN_W-1:0]       den_ff  [NUM_W];
   logic [SIDE_W-1:0]           side_ff [NUM_W];

   logic [1:0][NUM_W-1:0]       src_numq [NUM_W];
   logic [1:0][DEN_W-1:0]       src_rem  [NUM_W];
   logic [1:0][DEN_W-1:0]       src_den  [NUM_W];
   logic [DEN_W:0]              trial    [NUM_W][2];
   logic                        ge       [NUM_W][2];

   always_comb begin
      src_numq[0] = in_num;
      src_rem[0]  = '0;
      src_den[0]  = in_den;
      for (int s = 1; s < NUM_W; s++) begin
         src_numq[s] = numq_ff[s-1];
         src_rem[s]  = rem_ff[s-1];
         src_den[s]  = den_ff[s-1];
      end
      for (int s = 0; s < NUM_W; s++) begin
         for (int l = 0; l < 2; l++) begin
            trial[s][l] = {src_rem[s][l], src_numq[s][l][NUM_W-1]};
            ge[s][l]    = trial[s][l] >= {1'b0, src_den[s][l]};
            if (ge[s][l]) begin
               rem_in[s][l] = DEN_W'(trial[s][l] - {1'b0, src_den[s][l]});
            end else begin
               rem_in[s][l] = trial[s][l][DEN_W-1:0];
            end
            numq_in[s][l] = {src_numq[s][l][NUM_W-2:0], ge[s][l]};
         end
      end
   end

   assign vld_in = {vld_ff[NUM_W-2:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= in_side;
         for (int s = 0; s < NUM_W; s++) begin
            numq_ff[s] <= numq_in[s];
            rem_ff[s]  <= rem_in[s];
            den_ff[s]  <= src_den[s];
         end
         for (int s = 1; s < NUM_W; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   assign out_valid = vld_ff[NUM_W-1];
   assign out_quot  = numq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

### sv/plld_xform.sv
// world-to-device matrix stages: products, row sums with saturation,
// and sign/magnitude split for the depth divide; depends on plld_pkg
module plld_xform (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic signed [31:0]          in_x,
   input  logic signed [31:0]          in_y,
   input  logic signed [31:0]          in_z,
   input  logic [5:0][63:0]            rows,
   output logic                        out_valid,
   output logic [1:0][plld_pkg::DIV1_NUM_W-1:0] out_num,
   output logic [plld_pkg::DIV1_DEN_W-1:0]      out_den,
   output plld_pkg::div1_side_type     out_side
);
   import plld_pkg::*;

   logic [2:0]          vld_ff;
   logic signed [31:0]  pt [3];
   logic signed [31:0]  coef [3][4];
   logic signed [63:0]  prod_in [3][3];
   logic signed [63:0]  prod_ff [3][3];
   logic signed [49:0]  acc [3];
   sat_type             rs [3];
   logic signed [31:0]  xyz_in [3];
   logic signed [31:0]  xyz_ff [3];
   logic                bad_in, bad_ff;
   logic [31:0]         mag [3];
   logic [1:0][DIV1_NUM_W-1:0] num_ff;
   logic [DIV1_DEN_W-1:0]      den_ff;
   div1_side_type       side_in, side_ff;

   assign pt[0] = in_x;
   assign pt[1] = in_y;
   assign pt[2] = in_z;

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 4; c++) begin
            coef[r][c] = $signed(rows[r*2 + c/2][(c%2)*32 +: 32]);
         end
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = coef[r][c] * pt[c];
         end
      end
   end

   always_comb begin
      bad_in = 1'b0;
      for (int r = 0; r < 3; r++) begin
         acc[r] = 50'(coef[r][3])
                + 50'($signed(prod_ff[r][0][63:16]))
                + 50'($signed(prod_ff[r][1][63:16]))
                + 50'($signed(prod_ff[r][2][63:16]));
         rs[r]     = sat32(64'(acc[r]));
         xyz_in[r] = rs[r].val;
         bad_in    = bad_in | rs[r].bad;
      end
      if (acc[2] == '0) begin
         bad_in = 1'b1;
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         mag[r] = xyz_ff[r][31] ? 32'(-xyz_ff[r]) : 32'(xyz_ff[r]);
      end
      side_in.z     = xyz_ff[2];
      side_in.bad   = bad_ff;
      side_in.x_neg = xyz_ff[0][31];
      side_in.x_nz  = xyz_ff[0] != '0;
      side_in.y_neg = xyz_ff[1][31];
      side_in.y_nz  = xyz_ff[1] != '0;
      side_in.z_neg = xyz_ff[2][31];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         xyz_ff    <= xyz_in;
         bad_ff    <= bad_in;
         num_ff[0] <= {mag[0], 16'b0};
         num_ff[1] <= {mag[1], 16'b0};
         den_ff    <= mag[2];
         side_ff   <= side_in;
      end
   end

   assign out_valid = vld_ff[2];
   assign out_num   = num_ff;
   assign out_den   = den_ff;
   assign out_side  = side_ff;

endmodule

### sv/plld_recenter.sv
// signs and saturates the depth quotients, removes the principal point
// and splits the focal divide numerators; depends on plld_pkg
module plld_recenter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [1:0][plld_pkg::DIV1_NUM_W-1:0] in_quot,
   input  plld_pkg::div1_side_type     in_side,
   input  plld_pkg::lens_cfg_type      lens,
   output logic                        out_valid,
   output logic [1:0][plld_pkg::DIV2_NUM_W-1:0] out_num,
   output plld_pkg::div2_side_type     out_side
);
   import plld_pkg::*;

   logic [1:0]                vld_ff;
   logic signed [DIV1_NUM_W:0] sq [2];
   logic                      neg [2];
   logic                      nz [2];
   sat_type                   us [2];
   logic signed [31:0]        u_ff [2];
   logic signed [31:0]        z_ff;
   logic                      bad_in, bad_ff;
   logic [15:0]               ctr [2];
   logic signed [32:0]        diff [2];
   logic signed [36:0]        num [2];
   logic [1:0][DIV2_NUM_W-1:0] num_ff;
   div2_side_type             side_in, side_ff;

   assign neg[0] = in_side.x_neg ^ in_side.z_neg;
   assign neg[1] = in_side.y_neg ^ in_side.z_neg;
   assign nz[0]  = in_side.x_nz;
   assign nz[1]  = in_side.y_nz;
   assign ctr[0] = lens.cx;
   assign ctr[1] = lens.cy;

   always_comb begin
      bad_in = in_side.bad;
      for (int l = 0; l < 2; l++) begin
         sq[l] = $signed({1'b0, in_quot[l]});
         if (neg[l]) begin
            sq[l] = -sq[l];
         end
         us[l] = sat32(64'(sq[l]));
         if (in_side.z == '0) begin
            us[l] = zero_div(in_side.x_neg && (l == 0) || in_side.y_neg && (l == 1), nz[l]);
         end
         bad_in = bad_in | us[l].bad;
      end
   end

   always_comb begin
      for (int l = 0; l < 2; l++) begin
         diff[l] = 33'(u_ff[l]) - $signed({5'b0, ctr[l], 12'b0});
         num[l]  = $signed({diff[l], 4'b0});
      end
      side_in.z     = z_ff;
      side_in.bad   = bad_ff;
      side_in.x_neg = num[0][36];
      side_in.x_nz  = num[0] != '0;
      side_in.y_neg = num[1][36];
      side_in.y_nz  = num[1] != '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u_ff[0] <= us[0].val;
         u_ff[1] <= us[1].val;
         z_ff    <= in_side.z;
         bad_ff  <= bad_in;
         for (int l = 0; l < 2; l++) begin
            num_ff[l] <= num[l][36] ? DIV2_NUM_W'(-num[l]) : DIV2_NUM_W'(num[l]);
         end
         side_ff <= side_in;
      end
   end

   assign out_valid = vld_ff[1];
   assign out_num   = num_ff;
   assign out_side  = side_ff;

endmodule

### sv/plld_distort.sv
// normalized coordinates, radial and tangential distortion terms and
// mapping back to pixels, eleven register stages; depends on plld_pkg
module plld_distort (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        in_valid,
   input  logic [1:0][plld_pkg::DIV2_NUM_W-1:0] in_quot,
   input  plld_pkg::div2_side_type     in_side,
   input  plld_pkg::lens_cfg_type      lens,
   output logic                        out_valid,
   output logic signed [31:0]          out_px,
   output logic signed [31:0]          out_py,
   output logic signed [31:0]          out_z,
   output logic                        out_bad
);
   import plld_pkg::*;

   localparam int NSTAGE = 11;

   logic [NSTAGE-1:0]   vld_ff;
   logic signed [31:0]  z_ff [NSTAGE];
   logic                bad_ff [NSTAGE];

   // stage 1
   logic signed [DIV2_NUM_W:0] sq [2];
   sat_type             us [2];
   logic                neg [2];
   logic                nz [2];
   logic                bad1_in;
   logic signed [31:0]  u1_ff, v1_ff;
   // stage 2
   logic signed [63:0]  uup_ff, vvp_ff, uvp_ff;
   logic signed [31:0]  u2_ff, v2_ff;
   // stage 3
   sat_type             uus, vvs, uvs, r2s;
   logic signed [32:0]  r2sum;
   logic signed [31:0]  uu3_ff, vv3_ff, uv3_ff, r2_3_ff, u3_ff, v3_ff;
   // stage 4
   logic signed [63:0]  r4p_ff;
   logic signed [33:0]  tx_ff, ty_ff;
   logic signed [31:0]  uv4_ff, r2_4_ff, u4_ff, v4_ff;
   // stage 5
   sat_type             r4s;
   logic signed [31:0]  r4_5_ff, uv5_ff, r2_5_ff, u5_ff, v5_ff;
   logic signed [33:0]  tx5_ff, ty5_ff;
   // stage 6
   logic signed [47:0]  k1r2_ff, k2r4_ff, p1uv_ff, p2uv_ff;
   logic signed [49:0]  p2tx_ff, p1ty_ff;
   logic signed [31:0]  u6_ff, v6_ff;
   // stage 7
   logic signed [36:0]  fsum, tanx_in, tany_in;
   sat_type             fs;
   logic signed [31:0]  f7_ff, u7_ff, v7_ff;
   logic signed [36:0]  tanx7_ff, tany7_ff;
   // stage 8
   logic signed [63:0]  fu_ff, fv_ff;
   logic signed [36:0]  tanx8_ff, tany8_ff;
   // stage 9
   logic signed [49:0]  dxsum, dysum;
   sat_type             dxs, dys;
   logic signed [31:0]  dx9_ff, dy9_ff;
   // stage 10
   logic signed [16:0]  fxs, fys;
   logic signed [48:0]  dfx_ff, dfy_ff;
   // stage 11
   logic signed [46:0]  pxsum, pysum;
   sat_type             pxs, pys;
   logic signed [31:0]  px_ff, py_ff;

   logic [NSTAGE-1:0]   bad_in;

   assign neg[0] = in_side.x_neg;
   assign neg[1] = in_side.y_neg;
   assign nz[0]  = in_side.x_nz;
   assign nz[1]  = in_side.y_nz;

   always_comb begin
      bad1_in = in_side.bad;
      for (int l = 0; l < 2; l++) begin
         sq[l] = $signed({1'b0, in_quot[l]});
         if (neg[l]) begin
            sq[l] = -sq[l];
         end
         us[l] = sat32(64'(sq[l]));
         if ((l == 0 && lens.fx == '0) || (l == 1 && lens.fy == '0)) begin
            us[l] = zero_div(neg[l], nz[l]);
         end
         bad1_in = bad1_in | us[l].bad;
      end
   end

   always_comb begin
      uus   = sat32(64'($signed(uup_ff[63:16])));
      vvs   = sat32(64'($signed(vvp_ff[63:16])));
      uvs   = sat32(64'($signed(uvp_ff[63:16])));
      r2sum = 33'(uus.val) + 33'(vvs.val);
      r2s   = sat32(64'(r2sum));
      r4s   = sat32(64'($signed(r4p_ff[63:16])));
      fsum  = 37'sd65536 + 37'($signed(k1r2_ff[47:14])) + 37'($signed(k2r4_ff[47:14]));
      fs    = sat32(64'(fsum));
      tanx_in = 37'($signed(p1uv_ff[47:13])) + 37'($signed(p2tx_ff[49:14]));
      tany_in = 37'($signed(p2uv_ff[47:13])) + 37'($signed(p1ty_ff[49:14]));
      dxsum = 50'($signed(fu_ff[63:16])) + 50'(tanx8_ff);
      dysum = 50'($signed(fv_ff[63:16])) + 50'(tany8_ff);
      dxs   = sat32(64'(dxsum));
      dys   = sat32(64'(dysum));
      fxs   = $signed({1'b0, lens.fx});
      fys   = $signed({1'b0, lens.fy});
      pxsum = 47'($signed(dfx_ff[48:4])) + 47'($signed({1'b0, lens.cx, 12'b0})) + 47'sd32768;
      pysum = 47'($signed(dfy_ff[48:4])) + 47'($signed({1'b0, lens.cy, 12'b0})) + 47'sd32768;
      pxs   = sat32(64'(pxsum));
      pys   = sat32(64'(pysum));

      bad_in     = '0;
      bad_in[0]  = bad1_in;
      bad_in[1]  = bad_ff[0];
      bad_in[2]  = bad_ff[1] | uus.bad | vvs.bad | uvs.bad | r2s.bad;
      bad_in[3]  = bad_ff[2];
      bad_in[4]  = bad_ff[3] | r4s.bad;
      bad_in[5]  = bad_ff[4];
      bad_in[6]  = bad_ff[5] | fs.bad;
      bad_in[7]  = bad_ff[6];
      bad_in[8]  = bad_ff[7] | dxs.bad | dys.bad;
      bad_in[9]  = bad_ff[8];
      bad_in[10] = bad_ff[9] | pxs.bad | pys.bad;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NSTAGE-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z_ff[0] <= in_side.z;
         for (int s = 1; s < NSTAGE; s++) begin
            z_ff[s] <= z_ff[s-1];
         end
         for (int s = 0; s < NSTAGE; s++) begin
            bad_ff[s] <= bad_in[s];
         end
         u1_ff    <= us[0].val;
         v1_ff    <= us[1].val;
         uup_ff   <= u1_ff * u1_ff;
         vvp_ff   <= v1_ff * v1_ff;
         uvp_ff   <= u1_ff * v1_ff;
         u2_ff    <= u1_ff;
         v2_ff    <= v1_ff;
         uu3_ff   <= uus.val;
         vv3_ff   <= vvs.val;
         uv3_ff   <= uvs.val;
         r2_3_ff  <= r2s.val;
         u3_ff    <= u2_ff;
         v3_ff    <= v2_ff;
         r4p_ff   <= r2_3_ff * r2_3_ff;
         tx_ff    <= 34'(r2_3_ff) + 34'($signed({uu3_ff, 1'b0}));
         ty_ff    <= 34'(r2_3_ff) + 34'($signed({vv3_ff, 1'b0}));
         uv4_ff   <= uv3_ff;
         r2_4_ff  <= r2_3_ff;
         u4_ff    <= u3_ff;
         v4_ff    <= v3_ff;
         r4_5_ff  <= r4s.val;
         uv5_ff   <= uv4_ff;
         r2_5_ff  <= r2_4_ff;
         tx5_ff   <= tx_ff;
         ty5_ff   <= ty_ff;
         u5_ff    <= u4_ff;
         v5_ff    <= v4_ff;
         k1r2_ff  <= lens.k1 * r2_5_ff;
         k2r4_ff  <= lens.k2 * r4_5_ff;
         p1uv_ff  <= lens.p1 * uv5_ff;
         p2uv_ff  <= lens.p2 * uv5_ff;
         p2tx_ff  <= lens.p2 * tx5_ff;
         p1ty_ff  <= lens.p1 * ty5_ff;
         u6_ff    <= u5_ff;
         v6_ff    <= v5_ff;
         f7_ff    <= fs.val;
         tanx7_ff <= tanx_in;
         tany7_ff <= tany_in;
         u7_ff    <= u6_ff;
         v7_ff    <= v6_ff;
         fu_ff    <= f7_ff * u7_ff;
         fv_ff    <= f7_ff * v7_ff;
         tanx8_ff <= tanx7_ff;
         tany8_ff <= tany7_ff;
         dx9_ff   <= dxs.val;
         dy9_ff   <= dys.val;
         dfx_ff   <= dx9_ff * fxs;
         dfy_ff   <= dy9_ff * fys;
         px_ff    <= pxs.val;
         py_ff    <= pys.val;
      end
   end

   assign out_valid = vld_ff[NSTAGE-1];
   assign out_px    = px_ff;
   assign out_py    = py_ff;
   assign out_z     = z_ff[NSTAGE-1];
   assign out_bad   = bad_ff[NSTAGE-1];

endmodule

### sv/pinhole_project_lens_distort.sv
// top level: configuration registers, projection pipeline and output skid
// depends on plld_pkg, plld_xform, plld_div, plld_recenter, plld_distort
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tdata: point_x, point_y, point_z
//   rsp      out  rsp_tvalid/tready     tdata: pixel_x, pixel_y, depth; tuser: invalid
//   csr      in   csr_wr_en             csr_wr_index, csr_wr_data
//
// one point per cycle while the skid register is empty; a req transfer reaches rsp_tvalid
// through the 48-stage depth divider and the 37-stage focal divider
// synchronous active-high reset clears all valid bits and loads register defaults
// the pipeline stalls as a whole only while the skid register holds a result;
// a waiting output does not stop req transfers until the skid fills
module pinhole_project_lens_distort (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [95:0]                       req_tdata,   // point_x, point_y, point_z
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [95:0]                       rsp_tdata,   // pixel_x, pixel_y, depth
   output logic                              rsp_tuser,   // invalid
   input  logic                              csr_wr_en,
   input  logic [plld_pkg::CSR_IDX_W-1:0]    csr_wr_index,
   input  logic [63:0]                       csr_wr_data
);
   import plld_pkg::*;

   logic [CSR_COUNT-1:0][63:0] csr_ff;
   lens_cfg_type               lens;

   logic                       en;
   logic                       xf_valid;
   logic [1:0][DIV1_NUM_W-1:0] xf_num;
   logic [DIV1_DEN_W-1:0]      xf_den;
   div1_side_type              xf_side;
   logic                       d1_valid;
   logic [1:0][DIV1_NUM_W-1:0] d1_quot;
   div1_side_type              d1_side;
   logic                       rc_valid;
   logic [1:0][DIV2_NUM_W-1:0] rc_num;
   div2_side_type              rc_side;
   logic                       d2_valid;
   logic [1:0][DIV2_NUM_W-1:0] d2_quot;
   div2_side_type              d2_side;
   logic                       pipe_valid;
   logic signed [31:0]         pipe_px, pipe_py, pipe_z;
   logic                       pipe_bad;

   logic                       out_valid_ff;
   logic [96:0]                out_ff;
   logic                       skid_valid_ff;
   logic [96:0]                skid_ff;
   logic [96:0]                pipe_word;
   logic                       out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CSR_COUNT; i++) begin
            csr_ff[i] <= (i == int'(CSR_CENTER_FOCUS)) ? CENTER_FOCUS_RESET : 64'd0;
         end
      end else if (csr_wr_en) begin
         csr_ff[csr_wr_index] <= csr_wr_data;
      end
   end

   always_comb begin
      lens.cx = csr_ff[CSR_CENTER_FOCUS][15:0];
      lens.cy = csr_ff[CSR_CENTER_FOCUS][31:16];
      lens.fx = csr_ff[CSR_CENTER_FOCUS][47:32];
      lens.fy = csr_ff[CSR_CENTER_FOCUS][63:48];
      lens.k1 = $signed(csr_ff[CSR_DISTORTION][15:0]);
      lens.k2 = $signed(csr_ff[CSR_DISTORTION][31:16]);
      lens.p1 = $signed(csr_ff[CSR_DISTORTION][47:32]);
      lens.p2 = $signed(csr_ff[CSR_DISTORTION][63:48]);
   end

   assign en         = !skid_valid_ff;
   assign req_tready = en;

   plld_xform u_xform (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_tvalid),
      .in_x      ($signed(req_tdata[31:0])),
      .in_y      ($signed(req_tdata[63:32])),
      .in_z      ($signed(req_tdata[95:64])),
      .rows      (csr_ff[CSR_ROW2_HI:CSR_ROW0_LO]),
      .out_valid (xf_valid),
      .out_num   (xf_num),
      .out_den   (xf_den),
      .out_side  (xf_side)
   );

   plld_div #(
      .NUM_W  (DIV1_NUM_W),
      .DEN_W  (DIV1_DEN_W),
      .SIDE_W ($bits(div1_side_type))
   ) u_div_depth (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (xf_valid),
      .in_num    (xf_num),
      .in_den    ({xf_den, xf_den}),
      .in_side   (xf_side),
      .out_valid (d1_valid),
      .out_quot  (d1_quot),
      .out_side  (d1_side)
   );

   plld_recenter u_recenter (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d1_valid),
      .in_quot   (d1_quot),
      .in_side   (d1_side),
      .lens      (lens),
      .out_valid (rc_valid),
      .out_num   (rc_num),
      .out_side  (rc_side)
   );

   plld_div #(
      .NUM_W  (DIV2_NUM_W),
      .DEN_W  (DIV2_DEN_W),
      .SIDE_W ($bits(div2_side_type))
   ) u_div_focus (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (rc_valid),
      .in_num    (rc_num),
      .in_den    ({lens.fy, lens.fx}),
      .in_side   (rc_side),
      .out_valid (d2_valid),
      .out_quot  (d2_quot),
      .out_side  (d2_side)
   );

   plld_distort u_distort (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d2_valid),
      .in_quot   (d2_quot),
      .in_side   (d2_side),
      .lens      (lens),
      .out_valid (pipe_valid),
      .out_px    (pipe_px),
      .out_py    (pipe_py),
      .out_z     (pipe_z),
      .out_bad   (pipe_bad)
   );

   assign pipe_word = {pipe_bad, pipe_z, pipe_py, pipe_px};
   assign out_free  = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= pipe_valid;
         end
      end else if (pipe_valid && en) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_valid_ff ? skid_ff : pipe_word;
      end else if (pipe_valid && en) begin
         skid_ff <= pipe_word;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff[95:0];
   assign rsp_tuser  = out_ff[96];

endmodule

### verif/pinhole_project_lens_distort_tb.sv
// self-checking testbench for pinhole_project_lens_distort: random points and
// register settings, bit-exact projection predictor; depends on plld_pkg and the dut
`timescale 1ns / 1ps

module pinhole_project_lens_distort_tb;
   import plld_pkg::*;

   localparam int LATENCY   = 102;
   localparam int WDOG_MAX  = 20000;
   localparam int N_RANDOM  = 1350;

   typedef struct packed {
      logic signed [31:0] pz;
      logic signed [31:0] py;
      logic signed [31:0] px;
   } point_type;

   typedef struct packed {
      logic               inv;
      logic signed [31:0] dep;
      logic signed [31:0] pyo;
      logic signed [31:0] pxo;
   } pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_wr_index = '0;
   logic [63:0] csr_wr_data = '0;

   logic [63:0] regs [CSR_COUNT];
   point_type  pending_points[$];
   pixel_type  expected_pixels[$];
   int      errors = 0;
   int      wdog = 0;
   int      send_gap = 0;
   int      recv_gap = 0;
   int      recv_hold = 0;
   bit      calm = 1'b0;
   bit      send_pause = 1'b0;
   bit      req_fire = 1'b0;

   always #5 clock = ~clock;

   pinhole_project_lens_distort dut (.*);

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;
   endfunction

   function automatic longint clamp32(longint v, ref bit bad);
      if (v > 64'sd2147483647) begin
         bad = 1; return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         bad = 1; return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint safe_div(longint n, longint d, ref bit bad);
      if (d == 0) begin
         bad = 1;
         return n > 0 ? 64'sd2147483647 : (n < 0 ? -64'sd2147483648 : 0);
      end
      return clamp32(n / d, bad);
   endfunction

   function automatic longint matrix_coef(int r, int c);
      logic [63:0] w;
      w = regs[r * 2 + c / 2];
      return (c % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
   endfunction

   function automatic pixel_type project_point(point_type pt);
      longint p[3], acc[3];
      longint zz, xx, yy, ux, uy, cx, cy, fx, fy, u, v, k1, k2, p1, p2;
      longint uu, vv, uv, r2, r4, f, dx, dy, pxo, pyo;
      bit bad;
      pixel_type res;
      bad = 0;
      p[0] = pt.px; p[1] = pt.py; p[2] = pt.pz;
      for (int r = 0; r < 3; r++) begin
         acc[r] = matrix_coef(r, 3);
         for (int c = 0; c < 3; c++)
            acc[r] += floor_shift(matrix_coef(r, c) * p[c], 16);
      end
      if (acc[2] == 0) bad = 1;
      zz = clamp32(acc[2], bad);
      xx = clamp32(acc[0], bad);
      yy = clamp32(acc[1], bad);
      ux = safe_div(xx * 65536, zz, bad);
      uy = safe_div(yy * 65536, zz, bad);
      cx = regs[CSR_CENTER_FOCUS][15:0];
      cy = regs[CSR_CENTER_FOCUS][31:16];
      fx = regs[CSR_CENTER_FOCUS][47:32];
      fy = regs[CSR_CENTER_FOCUS][63:48];
      u = safe_div((ux - cx * 4096) * 16, fx, bad);
      v = safe_div((uy - cy * 4096) * 16, fy, bad);
      k1 = $signed(regs[CSR_DISTORTION][15:0]);
      k2 = $signed(regs[CSR_DISTORTION][31:16]);
      p1 = $signed(regs[CSR_DISTORTION][47:32]);
      p2 = $signed(regs[CSR_DISTORTION][63:48]);
      uu = clamp32(floor_shift(u * u, 16), bad);
      vv = clamp32(floor_shift(v * v, 16), bad);
      uv = clamp32(floor_shift(u * v, 16), bad);
      r2 = clamp32(uu + vv, bad);
      r4 = clamp32(floor_shift(r2 * r2, 16), bad);
      f = clamp32(65536 + floor_shift(k1 * r2, 14) + floor_shift(k2 * r4, 14), bad);
      dx = clamp32(floor_shift(f * u, 16) + floor_shift(p1 * uv, 13)
                   + floor_shift(p2 * (r2 + 2 * uu), 14), bad);
      dy = clamp32(floor_shift(f * v, 16) + floor_shift(p2 * uv, 13)
                   + floor_shift(p1 * (r2 + 2 * vv), 14), bad);
      pxo = clamp32(floor_shift(dx * fx, 4) + cx * 4096 + 32768, bad);
      pyo = clamp32(floor_shift(dy * fy, 4) + cy * 4096 + 32768, bad);
      res.pxo = pxo[31:0];
      res.pyo = pyo[31:0];
      res.dep = zz[31:0];
      res.inv = bad;
      return res;
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
         default: return $urandom;
      endcase
   endfunction

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_fire) begin
            expected_pixels.push_back(project_point(pending_points.pop_front()));
         end
         if (req_tvalid && !req_fire) begin
         end else if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            send_gap <= $urandom_range(1, 12);
            req_tvalid <= 1'b0;
         end else if (!send_pause && pending_points.size() > 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= pending_points[0];
         end else begin
            req_tvalid <= 1'b0;
         end
         if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!calm && $urandom_range(0, 15) == 0) begin
            recv_gap <= $urandom_range(1, 12);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      pixel_type got, exp_px;
      if (!reset) begin
         req_fire <= req_tvalid && req_tready;
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) wdog <= 0;
         else wdog <= wdog + 1;
         if (wdog >= WDOG_MAX) begin
            $display("%0t watchdog expired", $time);
            $display("TB_ERROR");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tuser, rsp_tdata};
            if (expected_pixels.size() == 0) begin
               $display("%0t unexpected transfer actual %h", $time, got);
               errors++;
            end else begin
               exp_px = expected_pixels.pop_front();
               if (got.pxo !== exp_px.pxo || got.pyo !== exp_px.pyo
                   || got.dep !== exp_px.dep || got.inv !== exp_px.inv) begin
                  $display("%0t mismatch exp x %h y %h z %h inv %b act x %h y %h z %h inv %b",
                           $time, exp_px.pxo, exp_px.pyo, exp_px.dep, exp_px.inv,
                           got.pxo, got.pyo, got.dep, got.inv);
                  errors++;
               end
            end
         end
      end
   end

   task automatic drain();
      while (pending_points.size() > 0 || expected_pixels.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [63:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_index <= idx;
      csr_wr_data <= val;
      regs[idx] = val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      point_type pt;
      pt.px = x; pt.py = y; pt.pz = z;
      pending_points.push_back(pt);
   endtask

   // camera setup: random registers when extreme, else near-unity x and z terms, small distortion
   task automatic program_camera(bit extreme);
      logic [31:0] d, o;
      for (int i = 0; i < 6; i++) begin
         if (extreme) begin
            write_reg(CSR_IDX_W'(i), {$urandom, $urandom});
         end else begin
            d = 32'h0001_0000 + 32'($urandom_range(0, 8191)) - 32'd4096;
            o = 32'($urandom_range(0, 32'h0003_FFFF)) - 32'h0002_0000;
            if (i == 4) o = 32'($urandom_range(0, 2047)) - 32'd1024;
            if (i == 5) o = 32'h0004_0000 + 32'($urandom_range(0, 32'h0004_0000));
            write_reg(CSR_IDX_W'(i), (i % 3 == (i / 2)) ? {o, d} :
                      ((i % 2 == 0) ? {o, d} : {o, d}));
         end
      end
      if (extreme) begin
         write_reg(CSR_CENTER_FOCUS, {$urandom, $urandom});
         write_reg(CSR_DISTORTION, {$urandom, $urandom});
      end else begin
         write_reg(CSR_CENTER_FOCUS, {16'($urandom_range(16, 20000)),
                   16'($urandom_range(16, 20000)), 16'($urandom), 16'($urandom)});
         write_reg(CSR_DISTORTION, {16'($urandom_range(0, 2000) - 1000),
                   16'($urandom_range(0, 2000) - 1000), 16'($urandom_range(0, 8000) - 4000),
                   16'($urandom_range(0, 8000) - 4000)});
      end
   endtask

   initial begin
      for (int i = 0; i < CSR_COUNT; i++) regs[i] = '0;
      regs[CSR_CENTER_FOCUS] = CENTER_FOCUS_RESET;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset registers: zero matrix gives zero depth
      push_point(32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
      drain();
      write_reg(CSR_ROW0_LO, 64'h0000_0000_0001_0000);
      write_reg(CSR_ROW1_LO, 64'h0001_0000_0000_0000);
      write_reg(CSR_ROW2_HI, 64'h0000_0000_0001_0000);
      push_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
      push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
      push_point(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      push_point(32'h0, 32'h0, 32'h0);
      push_point(32'h0001_0000, 32'hFFFF_0000, 32'h0);
      push_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
      push_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      drain();
      // zero focal length and extreme distortion
      write_reg(CSR_CENTER_FOCUS, 64'h0000_0000_FFFF_FFFF);
      write_reg(CSR_DISTORTION, 64'h7FFF_8000_7FFF_8000);
      push_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
      push_point(32'h0, 32'h0, 32'h0001_0000);
      push_point(32'h0100_0000, 32'hFF00_0000, 32'h0001_0000);
      drain();
      write_reg(CSR_CENTER_FOCUS, 64'hFFFF_FFFF_0000_0000);
      write_reg(CSR_DISTORTION, 64'h8000_7FFF_8000_7FFF);
      push_point(32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
      push_point(32'h0000_1000, 32'hFFFF_F000, 32'h0010_0000);
      drain();
      write_reg(CSR_ROW2_LO, 64'h7FFF_FFFF_8000_0000);
      write_reg(CSR_ROW2_HI, 64'h7FFF_FFFF_7FFF_FFFF);
      push_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      push_point(32'h1234_5678, 32'h8765_4321, 32'h0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         program_camera(phase == 2 || phase == 5);
         for (int n = 0; n < N_RANDOM / 6; n++)
            push_point(phase % 2 ? rand_coord() : 32'($urandom_range(0, 32'h000F_FFFF))
                       - 32'h0008_0000, rand_coord(), phase == 3 ?
                       32'($urandom_range(1, 32'h0010_0000)) : rand_coord());
         if (phase == 1) begin
            @(negedge clock);
            recv_hold <= 400;
         end
         if (phase == 3) begin
            while (pending_points.size() > N_RANDOM / 12) @(posedge clock);
            send_pause = 1'b1;
            while (expected_pixels.size() > 0) @(posedge clock);
            send_pause = 1'b0;
         end
         if (phase == 5) calm = 1'b1;
         drain();
      end

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

### sim.f
sv/plld_pkg.sv
sv/plld_div.sv
sv/plld_xform.sv
sv/plld_recenter.sv
sv/plld_distort.sv
sv/pinhole_project_lens_distort.sv
verif/pinhole_project_lens_distort_tb.sv
